FILE: sv/dedup_refcount_slot_pool_macros.svh
// Assertion macros used by the checker file of the slot pool.
`ifndef DEDUP_REFCOUNT_SLOT_POOL_MACROS_SVH
`define DEDUP_REFCOUNT_SLOT_POOL_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define DRSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define DRSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool assertion failed");

`endif

FILE: sv/drsp_pkg.sv
// Shared constants, codes and control types of the slot pool.
`timescale 1ns / 1ps
package drsp_pkg;
  localparam int SLOTS_DEF        = 256;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int COUNT_BITS_DEF   = 16;

  localparam int FUNC_W      = 3;
  localparam int IDX_PORT_W  = 8;
  localparam int HASH_W      = 64;
  localparam int DATA_PORT_W = 64;
  localparam int CNT_PORT_W  = 16;
  localparam int LIVE_PORT_W = 9;
  localparam int STATUS_W    = 2;

  localparam logic [FUNC_W-1:0] FN_ACQUIRE = 3'd0;
  localparam logic [FUNC_W-1:0] FN_DEDUP   = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RETAIN  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_READ    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTLIVE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_SAT     = 2'd3;

  typedef struct packed {
    logic load;
    logic dec;
    logic scan;
    logic grant;
    logic pop;
    logic access;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              hash_nz;
    logic              depth_nz;
    logic              si_ok;
    logic              scan_hit;
    logic              scan_miss;
    logic              out_free;
  } dp_sts_t;
endpackage

FILE: sv/drsp_ctrl.sv
// Sequencing state machine of the slot pool.
`timescale 1ns / 1ps
module drsp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  drsp_pkg::dp_sts_t sts,
  output drsp_pkg::dp_cmd_t cmd
);
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_DEC    = 7'b0000010,
    S_SCAN   = 7'b0000100,
    S_GRANT  = 7'b0001000,
    S_POP    = 7'b0010000,
    S_ACCESS = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.dec = 1'b1;
        if (sts.func == drsp_pkg::FN_ACQUIRE ||
            (sts.func == drsp_pkg::FN_DEDUP && !sts.hash_nz)) begin
          state_nxt = S_GRANT;
        end else if (sts.func == drsp_pkg::FN_DEDUP) begin
          state_nxt = S_SCAN;
        end else if (sts.func == drsp_pkg::FN_RETAIN || sts.func == drsp_pkg::FN_RELEASE ||
                     sts.func == drsp_pkg::FN_READ) begin
          state_nxt = sts.si_ok ? S_ACCESS : S_EMIT;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_hit) begin
          state_nxt = S_EMIT;
        end else if (sts.scan_miss) begin
          state_nxt = S_GRANT;
        end
      end
      S_GRANT: begin
        cmd.grant = 1'b1;
        state_nxt = sts.depth_nz ? S_POP : S_EMIT;
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_EMIT;
      end
      S_ACCESS: begin
        cmd.access = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end
endmodule

FILE: sv/drsp_dp.sv
// Datapath of the slot pool: slot memories, free stack, counters and result register.
`timescale 1ns / 1ps
module drsp_dp #(
  parameter int SLOTS        = drsp_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = drsp_pkg::PAYLOAD_BITS_DEF,
  parameter int COUNT_BITS   = drsp_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  drsp_pkg::dp_cmd_t                    cmd,
  output drsp_pkg::dp_sts_t                    sts,
  input  logic [drsp_pkg::FUNC_W-1:0]          in_func,
  input  logic [drsp_pkg::IDX_PORT_W-1:0]      in_slot_index,
  input  logic [drsp_pkg::HASH_W-1:0]          in_content_hash,
  input  logic [drsp_pkg::DATA_PORT_W-1:0]     in_entry_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [drsp_pkg::IDX_PORT_W-1:0]      out_result_index,
  output logic [drsp_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_dedup_hit,
  output logic [drsp_pkg::CNT_PORT_W-1:0]      out_ref_count,
  output logic [drsp_pkg::LIVE_PORT_W-1:0]     out_live_total,
  output logic [drsp_pkg::DATA_PORT_W-1:0]     out_read_data
);
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int IPW   = drsp_pkg::IDX_PORT_W;
  localparam int CPW   = drsp_pkg::CNT_PORT_W;
  localparam int LPW   = drsp_pkg::LIVE_PORT_W;
  localparam int DPW   = drsp_pkg::DATA_PORT_W;

  logic [COUNT_BITS-1:0]      cnt_mem [SLOTS];
  logic [drsp_pkg::HASH_W-1:0] tag_mem [SLOTS];
  logic [PAYLOAD_BITS-1:0]    pay_mem [SLOTS];
  logic [IDX_W-1:0]           stk_mem [SLOTS];

  logic [COUNT_BITS-1:0]       cnt_q;
  logic [drsp_pkg::HASH_W-1:0] tag_q;
  logic [PAYLOAD_BITS-1:0]     pay_q;
  logic [IDX_W-1:0]            stk_q;

  logic [drsp_pkg::FUNC_W-1:0] func_r;
  logic [IPW-1:0]              si_r;
  logic [drsp_pkg::HASH_W-1:0] hash_r;
  logic [PAYLOAD_BITS-1:0]     data_r;
  logic [CNT_W-1:0]            depth_r;
  logic [CNT_W-1:0]            mark_r;
  logic [CNT_W-1:0]            live_r;
  logic [CNT_W-1:0]            scan_cnt_r;
  logic                        cmp_vld_r;
  logic [IDX_W-1:0]            cmp_idx_r;

  logic [IPW-1:0]              res_idx_r;
  logic [drsp_pkg::STATUS_W-1:0] res_st_r;
  logic                        res_hit_r;
  logic [CPW-1:0]              res_cnt_r;
  logic [DPW-1:0]              res_data_r;
  logic                        out_valid_r;

  logic [IDX_W-1:0]            rd_addr;
  logic [IDX_W-1:0]            si_idx;
  logic [IDX_W-1:0]            stk_rd_addr;
  logic [IDX_W-1:0]            g_idx;
  logic                        scan_issue;
  logic                        match;
  logic                        sat_q;
  logic                        cnt_nz;
  logic [COUNT_BITS-1:0]       cnt_inc;
  logic [COUNT_BITS-1:0]       cnt_dec;
  logic                        depth_nz;
  logic                        pool_full;
  logic                        commit;
  logic                        free_slot;
  logic                        out_free;
  logic                        cnt_we;
  logic [IDX_W-1:0]            cnt_wa;
  logic [COUNT_BITS-1:0]       cnt_wd;

  assign si_idx      = IDX_W'(si_r);
  assign rd_addr     = cmd.scan ? scan_cnt_r[IDX_W-1:0] : si_idx;
  assign stk_rd_addr = IDX_W'(depth_r - 1'b1);
  assign scan_issue  = (scan_cnt_r < mark_r);
  assign cnt_nz      = (cnt_q != '0);
  assign match       = cmp_vld_r && cnt_nz && (tag_q == hash_r);
  assign sat_q       = &cnt_q;
  assign cnt_inc     = cnt_q + 1'b1;
  assign cnt_dec     = cnt_q - 1'b1;
  assign depth_nz    = (depth_r != '0);
  assign pool_full   = (mark_r == CNT_W'(SLOTS));
  assign g_idx       = cmd.pop ? stk_q : IDX_W'(mark_r);
  assign commit      = (cmd.grant && !depth_nz && !pool_full) || cmd.pop;
  assign free_slot   = cmd.access && (func_r == drsp_pkg::FN_RELEASE) &&
                       (cnt_q == COUNT_BITS'(1));
  assign out_free    = !out_valid_r || !out_stall;

  always_comb begin
    sts.func      = func_r;
    sts.hash_nz   = (hash_r != '0);
    sts.depth_nz  = depth_nz;
    sts.si_ok     = (32'(si_r) < 32'(mark_r));
    sts.scan_hit  = match;
    sts.scan_miss = !scan_issue && !match;
    sts.out_free  = out_free;
  end

  always_comb begin
    cnt_we = 1'b0;
    cnt_wa = si_idx;
    cnt_wd = cnt_inc;
    if (commit) begin
      cnt_we = 1'b1;
      cnt_wa = g_idx;
      cnt_wd = COUNT_BITS'(1);
    end else if (cmd.scan && match && !sat_q) begin
      cnt_we = 1'b1;
      cnt_wa = cmp_idx_r;
    end else if (cmd.access && cnt_nz) begin
      if (func_r == drsp_pkg::FN_RETAIN && !sat_q) begin
        cnt_we = 1'b1;
      end else if (func_r == drsp_pkg::FN_RELEASE) begin
        cnt_we = 1'b1;
        cnt_wd = cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_q <= cnt_mem[rd_addr];
    tag_q <= tag_mem[rd_addr];
    pay_q <= pay_mem[rd_addr];
    stk_q <= stk_mem[stk_rd_addr];
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (commit) begin
      tag_mem[g_idx] <= (func_r == drsp_pkg::FN_DEDUP) ? hash_r : '0;
      pay_mem[g_idx] <= data_r;
    end
    if (free_slot) begin
      stk_mem[IDX_W'(depth_r)] <= si_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r     <= '0;
      mark_r      <= '0;
      live_r      <= '0;
      scan_cnt_r  <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.dec) begin
        scan_cnt_r <= '0;
        cmp_vld_r  <= 1'b0;
      end
      if (cmd.scan) begin
        if (scan_issue) begin
          scan_cnt_r <= scan_cnt_r + 1'b1;
        end
        cmp_vld_r <= scan_issue;
      end
      if (cmd.grant && depth_nz) begin
        depth_r <= depth_r - 1'b1;
      end
      if (cmd.grant && !depth_nz && !pool_full) begin
        mark_r <= mark_r + 1'b1;
      end
      if (commit) begin
        live_r <= live_r + 1'b1;
      end
      if (free_slot) begin
        depth_r <= depth_r + 1'b1;
        live_r  <= live_r - 1'b1;
      end
      if (out_free) begin
        out_valid_r <= cmd.emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      si_r   <= in_slot_index;
      hash_r <= in_content_hash;
      data_r <= PAYLOAD_BITS'(in_entry_data);
    end
    if (cmd.scan) begin
      cmp_idx_r <= scan_cnt_r[IDX_W-1:0];
    end
    if (cmd.dec) begin
      res_hit_r  <= 1'b0;
      res_cnt_r  <= '0;
      res_data_r <= '0;
      if (func_r > drsp_pkg::FN_READ) begin
        res_idx_r <= '0;
        res_st_r  <= drsp_pkg::ST_OK;
      end else begin
        res_idx_r <= si_r;
        res_st_r  <= drsp_pkg::ST_NOTLIVE;
      end
    end
    if (cmd.scan && match) begin
      res_idx_r  <= IPW'(cmp_idx_r);
      res_st_r   <= sat_q ? drsp_pkg::ST_SAT : drsp_pkg::ST_OK;
      res_hit_r  <= 1'b1;
      res_cnt_r  <= sat_q ? CPW'(cnt_q) : CPW'(cnt_inc);
      res_data_r <= '0;
    end
    if (cmd.grant) begin
      res_hit_r  <= 1'b0;
      res_data_r <= '0;
      if (pool_full) begin
        res_idx_r <= '0;
        res_st_r  <= drsp_pkg::ST_FULL;
        res_cnt_r <= '0;
      end else begin
        res_idx_r <= IPW'(mark_r);
        res_st_r  <= drsp_pkg::ST_OK;
        res_cnt_r <= CPW'(1);
      end
    end
    if (cmd.pop) begin
      res_idx_r <= IPW'(stk_q);
      res_st_r  <= drsp_pkg::ST_OK;
      res_cnt_r <= CPW'(1);
    end
    if (cmd.access) begin
      res_idx_r  <= si_r;
      res_hit_r  <= 1'b0;
      res_data_r <= '0;
      if (!cnt_nz) begin
        res_st_r  <= drsp_pkg::ST_NOTLIVE;
        res_cnt_r <= '0;
      end else if (func_r == drsp_pkg::FN_RETAIN) begin
        res_st_r  <= sat_q ? drsp_pkg::ST_SAT : drsp_pkg::ST_OK;
        res_cnt_r <= sat_q ? CPW'(cnt_q) : CPW'(cnt_inc);
      end else if (func_r == drsp_pkg::FN_RELEASE) begin
        res_st_r  <= drsp_pkg::ST_OK;
        res_cnt_r <= CPW'(cnt_dec);
      end else begin
        res_st_r   <= drsp_pkg::ST_OK;
        res_cnt_r  <= CPW'(cnt_q);
        res_data_r <= DPW'(pay_q);
      end
    end
    if (cmd.emit && out_free) begin
      out_result_index <= res_idx_r;
      out_status       <= res_st_r;
      out_dedup_hit    <= res_hit_r;
      out_ref_count    <= res_cnt_r;
      out_live_total   <= LPW'(live_r);
      out_read_data    <= res_data_r;
    end
  end

  assign out_valid = out_valid_r;
endmodule

FILE: sv/dedup_refcount_slot_pool.sv
// Top level of the reference-counted slot pool with content-hash deduplication.
// Each transaction is taken while the pool is idle and gives exactly one result. It passes
// through a decode state and ends in an emit state. An unused function code, or a retain,
// release or read of a slot at or above the high-water mark, goes from decode straight to emit.
// A retain, release or read of a slot below the mark passes through an access state. An acquire
// passes through a grant state, which takes the next never-used slot or finds the pool full,
// and then through a pop state when it takes a slot from the free stack. A dedup acquire with a
// nonzero hash first walks the slots used so far, one slot a cycle through the single read port
// of the count and tag memories; a hit ends the walk and a miss goes on to the grant state. The
// next transaction can be accepted in the cycle in which the result appears. A result held by
// out_stall does not stop the next transaction being accepted, but that transaction's result
// waits until the held one has gone. Slot counts above the high-water mark are never read, so
// no clearing pass is needed after reset.
`timescale 1ns / 1ps
module dedup_refcount_slot_pool #(
  parameter int SLOTS        = drsp_pkg::SLOTS_DEF,
  parameter int PAYLOAD_BITS = drsp_pkg::PAYLOAD_BITS_DEF,
  parameter int COUNT_BITS   = drsp_pkg::COUNT_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [drsp_pkg::FUNC_W-1:0]          in_func,
  input  logic [drsp_pkg::IDX_PORT_W-1:0]      in_slot_index,
  input  logic [drsp_pkg::HASH_W-1:0]          in_content_hash,
  input  logic [drsp_pkg::DATA_PORT_W-1:0]     in_entry_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [drsp_pkg::IDX_PORT_W-1:0]      out_result_index,
  output logic [drsp_pkg::STATUS_W-1:0]        out_status,
  output logic                                 out_dedup_hit,
  output logic [drsp_pkg::CNT_PORT_W-1:0]      out_ref_count,
  output logic [drsp_pkg::LIVE_PORT_W-1:0]     out_live_total,
  output logic [drsp_pkg::DATA_PORT_W-1:0]     out_read_data
);
  drsp_pkg::dp_cmd_t cmd;
  drsp_pkg::dp_sts_t sts;

  drsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  drsp_dp #(
    .SLOTS        (SLOTS),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_func          (in_func),
    .in_slot_index    (in_slot_index),
    .in_content_hash  (in_content_hash),
    .in_entry_data    (in_entry_data),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .out_status       (out_status),
    .out_dedup_hit    (out_dedup_hit),
    .out_ref_count    (out_ref_count),
    .out_live_total   (out_live_total),
    .out_read_data    (out_read_data)
  );
endmodule

FILE: sv/drsp_checker.sv
// Port-level checker of the slot pool and its binding to the top level.
`timescale 1ns / 1ps
`include "dedup_refcount_slot_pool_macros.svh"
module drsp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic [drsp_pkg::IDX_PORT_W-1:0]      out_result_index,
  input logic [drsp_pkg::STATUS_W-1:0]        out_status,
  input logic                                 out_dedup_hit,
  input logic [drsp_pkg::CNT_PORT_W-1:0]      out_ref_count,
  input logic [drsp_pkg::DATA_PORT_W-1:0]     out_read_data
);
  `DRSP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_index) && $stable(out_ref_count))
  `DRSP_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `DRSP_ASSERT_NOW(a_full_result, out_valid && out_status == drsp_pkg::ST_FULL, out_result_index == '0 && out_ref_count == '0 && !out_dedup_hit)
  `DRSP_ASSERT_NOW(a_notlive_result, out_valid && out_status == drsp_pkg::ST_NOTLIVE, out_ref_count == '0 && out_read_data == '0 && !out_dedup_hit)
  `DRSP_ASSERT_NOW(a_hit_result, out_valid && out_dedup_hit, (out_status == drsp_pkg::ST_OK || out_status == drsp_pkg::ST_SAT) && out_read_data == '0)
endmodule

bind dedup_refcount_slot_pool drsp_checker u_drsp_checker (.*);
